// File: hw/rtl/isq_pkg.sv
// Package with the shared types and constants of the indexed shift queue.
`default_nettype none
package isq_pkg;

  localparam int DepthDefault     = 16;
  localparam int DataWidthDefault = 8;
  localparam int LimitW           = 5;
  localparam int LimitReset       = 16;
  localparam int PosMaxW          = 8;
  localparam int ApbDataW         = 32;
  localparam int ApbAddrW         = 3;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } isq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } isq_status_t;

  typedef enum logic [0:0] {
    REG_LIMIT = 1'b0
  } isq_reg_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic               push;
    logic               take;
    logic [PosMaxW-1:0] wr_pos;
    logic [PosMaxW-1:0] take_pos;
    logic [PosMaxW-1:0] rd_pos;
  } isq_cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/isq_req_if.sv
// Request channel interface carrying one queue operation.
`default_nettype none
interface isq_req_if #(
  parameter int DATA_WIDTH = isq_pkg::DataWidthDefault,
  parameter int POS_W      = 4
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            opcode;
  logic [DATA_WIDTH-1:0] push_value;
  logic [POS_W-1:0]      position;

  modport source (output valid, output opcode, output push_value, output position,
                  input ready);
  modport sink (input valid, input opcode, input push_value, input position,
                output ready);
endinterface
`default_nettype wire

// File: hw/rtl/isq_rsp_if.sv
// Response channel interface carrying the result of one queue operation.
`default_nettype none
interface isq_rsp_if #(
  parameter int DATA_WIDTH = isq_pkg::DataWidthDefault,
  parameter int CNT_W      = 5
);
  logic                  valid;
  logic                  ready;
  logic [DATA_WIDTH-1:0] data_out;
  logic [1:0]            status;
  logic [CNT_W-1:0]      occupancy;
  logic                  is_empty;
  logic                  is_full;

  modport source (output valid, output data_out, output status, output occupancy,
                  output is_empty, output is_full, input ready);
  modport sink (input valid, input data_out, input status, input occupancy,
                input is_empty, input is_full, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/indexed_shift_queue_core.sv
// Top level of the indexed shift queue: request decode, cell chain and result register.
`default_nettype none
// The queue holds up to DEPTH words in a chain of cells, position 0 at the head.
// Each request is push, pop front, remove at a position or read at a position, and
// gives exactly one response with the word, a status, the occupancy and the empty and
// full flags. A request is accepted in every cycle in which the response register is
// free or being emptied, and its response appears in the next cycle, so the
// block sustains one request per cycle while responses are taken; all cells load or
// shift in the same edge. The limit register (address 0) caps the number of entries a
// push may fill, resets to 16; it should be written only while no request is in flight.
module indexed_shift_queue_core #(
  parameter int DEPTH      = isq_pkg::DepthDefault,
  parameter int DATA_WIDTH = isq_pkg::DataWidthDefault
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  isq_req_if.sink                             req,
  isq_rsp_if.source                           rsp,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [isq_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [isq_pkg::ApbDataW-1:0]   pwdata,
  output logic      [isq_pkg::ApbDataW-1:0]   prdata,
  output logic                                pready
);

  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > isq_pkg::LimitW) ? CNT_W : isq_pkg::LimitW;
  localparam logic [CMP_W-1:0] DepthC = CMP_W'(DEPTH);

  logic [isq_pkg::LimitW-1:0] limit;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;

  logic                  rsp_valid;
  logic [DATA_WIDTH-1:0] rsp_data;
  logic [1:0]            rsp_status;
  logic [CNT_W-1:0]      rsp_occupancy;
  logic                  rsp_is_empty;
  logic                  rsp_is_full;

  logic                  accept;
  logic                  cfg_write;
  isq_pkg::isq_op_t      op;
  isq_pkg::isq_status_t  status;
  logic [CMP_W-1:0]      eff_limit;
  logic [CMP_W-1:0]      count_x;
  logic [CMP_W-1:0]      count_next_x;
  logic                  pos_bad;
  logic                  push_ok;
  logic                  take_ok;
  logic                  read_ok;
  logic [POS_W-1:0]      rd_pos;
  logic [DATA_WIDTH-1:0] read_word;
  isq_pkg::isq_cmd_t     cmd;

  logic [DATA_WIDTH-1:0] chain [DEPTH+1];
  logic [DATA_WIDTH-1:0] hits  [DEPTH];

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= isq_pkg::LimitW'(isq_pkg::LimitReset);
    end else if (cfg_write && (paddr[2] == isq_pkg::REG_LIMIT)) begin
      limit <= pwdata[isq_pkg::LimitW-1:0];
    end
  end

  assign prdata = (paddr[2] == isq_pkg::REG_LIMIT) ?
                  isq_pkg::ApbDataW'(limit) : '0;

  // Request decode.
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign op        = isq_pkg::isq_op_t'(req.opcode);

  assign eff_limit = (CMP_W'(limit) > DepthC) ? DepthC : CMP_W'(limit);
  assign count_x   = CMP_W'(count);
  assign pos_bad   = CNT_W'(req.position) >= count;

  always_comb begin
    push_ok    = 1'b0;
    take_ok    = 1'b0;
    read_ok    = 1'b0;
    rd_pos     = req.position;
    status     = isq_pkg::ST_OK;
    count_next = count;
    unique case (op)
      isq_pkg::OP_PUSH: begin
        if (count_x >= eff_limit) begin
          status = isq_pkg::ST_FULL;
        end else begin
          push_ok    = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      isq_pkg::OP_POP: begin
        rd_pos = '0;
        if (count == '0) begin
          status = isq_pkg::ST_EMPTY;
        end else begin
          take_ok    = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      isq_pkg::OP_REMOVE: begin
        if (count == '0) begin
          status = isq_pkg::ST_EMPTY;
        end else if (pos_bad) begin
          status = isq_pkg::ST_RANGE;
        end else begin
          take_ok    = 1'b1;
          count_next = count - CNT_W'(1);
        end
      end
      isq_pkg::OP_READ: begin
        if (count == '0) begin
          status = isq_pkg::ST_EMPTY;
        end else if (pos_bad) begin
          status = isq_pkg::ST_RANGE;
        end else begin
          read_ok = 1'b1;
        end
      end
      default: begin
        status = isq_pkg::ST_OK;
      end
    endcase
  end

  assign count_next_x = CMP_W'(count_next);

  assign cmd.push     = accept && push_ok;
  assign cmd.take     = accept && take_ok;
  assign cmd.wr_pos   = isq_pkg::PosMaxW'(count);
  assign cmd.take_pos = isq_pkg::PosMaxW'(rd_pos);
  assign cmd.rd_pos   = isq_pkg::PosMaxW'(rd_pos);

  // Cell chain; the slot past the last cell feeds zeros.
  assign chain[DEPTH] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    isq_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .INDEX     (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .push_value(req.push_value),
      .next_data (chain[i+1]),
      .word      (chain[i]),
      .hit_data  (hits[i])
    );
  end

  always_comb begin
    read_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      read_word = read_word | hits[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data      <= (take_ok || read_ok) ? read_word : '0;
      rsp_status    <= status;
      rsp_occupancy <= count_next;
      rsp_is_empty  <= (count_next == '0);
      rsp_is_full   <= (count_next_x >= eff_limit);
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.data_out  = rsp_data;
  assign rsp.status    = rsp_status;
  assign rsp.occupancy = rsp_occupancy;
  assign rsp.is_empty  = rsp_is_empty;
  assign rsp.is_full   = rsp_is_full;

  // The stored count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= DepthC)
    else $error("queue count exceeds depth");

  // Every accepted request leaves a response behind it.
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp_valid)
    else $error("accepted request produced no response");

  // A read leaves the queue unchanged.
  a_read_keeps: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == isq_pkg::OP_READ)) |=> (count == $past(count)))
    else $error("read changed the queue count");

  // A refused request returns a zero word.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status != isq_pkg::ST_OK)) |-> (rsp_data == '0))
    else $error("refused request returned data");

endmodule
`default_nettype wire

// File: hw/rtl/isq_cell.sv
// One storage cell of the queue chain: holds a word, loads, or takes its neighbor's word.
`default_nettype none
module isq_cell #(
  parameter int DATA_WIDTH = isq_pkg::DataWidthDefault,
  parameter int INDEX      = 0
) (
  input  wire logic                  clk,
  input  wire isq_pkg::isq_cmd_t     cmd,
  input  wire logic [DATA_WIDTH-1:0] push_value,
  input  wire logic [DATA_WIDTH-1:0] next_data,
  output logic      [DATA_WIDTH-1:0] word,
  output logic      [DATA_WIDTH-1:0] hit_data
);

  localparam logic [isq_pkg::PosMaxW-1:0] MyPos = isq_pkg::PosMaxW'(INDEX);

  logic load_hit;
  logic shift_hit;

  assign load_hit  = cmd.push && (cmd.wr_pos == MyPos);
  assign shift_hit = cmd.take && (MyPos >= cmd.take_pos);

  always_ff @(posedge clk) begin
    if (load_hit) begin
      word <= push_value;
    end else if (shift_hit) begin
      word <= next_data;
    end
  end

  assign hit_data = (cmd.rd_pos == MyPos) ? word : '0;

endmodule
`default_nettype wire
